FILE: src/segmented_prime_sieve_counter_macros.svh
// Assertion macros shared by the checker of the prime sieve counter.
// Depends on nothing; included by the checker file.
`ifndef SEGMENTED_PRIME_SIEVE_COUNTER_MACROS_SVH
`define SEGMENTED_PRIME_SIEVE_COUNTER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define SPSC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sieve counter check failed");

// Next-cycle implication.
`define SPSC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sieve counter check failed");

`endif

FILE: src/spsc_pkg.sv
// Shared types, constants and helpers of the segmented prime sieve counter.
// Depends on nothing.
package spsc_pkg;

   localparam int SEG_BITS        = 65536;
   localparam int SEG_AW          = $clog2(SEG_BITS);
   localparam int MAX_BASE_PRIMES = 8192;
   localparam int BASE_AW         = $clog2(MAX_BASE_PRIMES);
   localparam int CNT_W           = $clog2(MAX_BASE_PRIMES + 1);
   localparam int ADDR_W          = SEG_AW + 1;
   localparam int OFF_W           = SEG_AW + 2;

   localparam logic [ADDR_W-1:0] SEG_LAST    = ADDR_W'(SEG_BITS - 1);
   localparam logic [27:0]       TOTAL_MAX   = 28'hFFFFFFF;
   localparam logic [16:0]       SEGCNT_MAX  = 17'h1FFFF;
   localparam logic [31:0]       LIMIT_RESET = 32'd100000000;
   localparam logic [31:0]       PRIME_MAX   = 32'd65535;

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_SWEEP   = 2'd1,
      CMD_QUERY   = 2'd2,
      CMD_RESTART = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_PAST      = 3'd2,
      ST_OUTSIDE   = 3'd3,
      ST_NOT_ASCND = 3'd4
   } status_type;

   typedef struct packed {
      cmd_type          op;
      status_type       status;
      logic [31:0]      value;
      logic [31:0]      low;
      logic [31:0]      high;
      logic [CNT_W-1:0] count;
   } item_type;

   function automatic logic [27:0] sat_add(input logic [27:0] a, input logic [27:0] b);
      logic [28:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[28] ? TOTAL_MAX : s[27:0];
   endfunction

endpackage

FILE: src/spsc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module spsc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

FILE: src/spsc_front.sv
// Front end: accepts commands, holds the limit register and classifies each beat.
// Depends on spsc_pkg.
module spsc_front
   import spsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_value,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   input  logic        done,
   output logic        busy,
   output logic        push,
   output item_type    push_item
);
   logic [31:0]      limit_ff, limit_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      last_ff, last_in;
   logic [32:0]      next_low_ff, next_low_in;
   logic             valid_ff, valid_in;
   logic [31:0]      low_ff, low_in;
   logic [31:0]      high_ff, high_in;
   logic             busy_ff, busy_in;
   logic [32:0]      high_full;
   logic [31:0]      high_cut;
   cmd_type          cmd;

   assign cmd       = cmd_type'(req_cmd);
   assign push      = start && !busy_ff;
   assign busy      = busy_ff;
   assign high_full = next_low_ff + 33'(SEG_BITS - 1);
   assign high_cut  = (high_full > {1'b0, limit_ff}) ? limit_ff : high_full[31:0];

   always_comb begin
      limit_in    = csr_we ? csr_wdata : limit_ff;
      count_in    = count_ff;
      last_in     = last_ff;
      next_low_in = next_low_ff;
      valid_in    = valid_ff;
      low_in      = low_ff;
      high_in     = high_ff;
      busy_in     = busy_ff;
      push_item   = '{op: cmd, status: ST_OK, value: req_value, low: next_low_ff[31:0],
                      high: high_cut, count: count_ff};
      if (done) begin
         busy_in = 1'b0;
      end
      if (push) begin
         busy_in = 1'b1;
         unique case (cmd)
            CMD_LOAD: begin
               if (count_ff == CNT_W'(MAX_BASE_PRIMES)) begin
                  push_item.status = ST_FULL;
               end else if (req_value < 32'd2 || req_value > PRIME_MAX ||
                            (count_ff != '0 && req_value[15:0] <= last_ff)) begin
                  push_item.status = ST_NOT_ASCND;
               end else begin
                  count_in = count_ff + 1'b1;
                  last_in  = req_value[15:0];
               end
            end
            CMD_SWEEP: begin
               if (next_low_ff > {1'b0, limit_ff}) begin
                  push_item.status = ST_PAST;
               end else begin
                  low_in      = next_low_ff[31:0];
                  high_in     = high_cut;
                  valid_in    = 1'b1;
                  next_low_in = {1'b0, high_cut} + 33'd1;
               end
            end
            CMD_QUERY: begin
               if (!valid_ff || req_value < low_ff || req_value > high_ff) begin
                  push_item.status = ST_OUTSIDE;
               end
            end
            CMD_RESTART: begin
               next_low_in = '0;
               valid_in    = 1'b0;
               low_in      = '0;
               high_in     = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= LIMIT_RESET;
         count_ff    <= '0;
         last_ff     <= '0;
         next_low_ff <= '0;
         valid_ff    <= 1'b0;
         low_ff      <= '0;
         high_ff     <= '0;
         busy_ff     <= 1'b0;
      end else begin
         limit_ff    <= limit_in;
         count_ff    <= count_in;
         last_ff     <= last_in;
         next_low_ff <= next_low_in;
         valid_ff    <= valid_in;
         low_ff      <= low_in;
         high_ff     <= high_in;
         busy_ff     <= busy_in;
      end
   end
endmodule

FILE: src/spsc_fifo.sv
// Two-entry queue of classified commands between the front and back ends.
// Depends on spsc_pkg.
module spsc_fifo
   import spsc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     empty,
   output item_type head
);
   item_type   mem_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] used_ff, used_in;

   assign empty = (used_ff == 2'd0);
   assign head  = mem_ff[rd_ff];

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      used_in = used_ff;
      if (push && used_ff != 2'd2) begin
         wr_in = !wr_ff;
      end
      if (pop && !empty) begin
         rd_in = !rd_ff;
      end
      used_in = used_ff + 2'((push && used_ff != 2'd2) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
   end

   always_ff @(posedge clock) begin
      if (push && used_ff != 2'd2) begin
         mem_ff[wr_ff] <= push_item;
      end
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         used_ff <= 2'd0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         used_ff <= used_in;
      end
   end
endmodule

FILE: src/spsc_back.sv
// Back end: base prime table, composite bitmap, sweep and count sequencer, totals.
// Depends on spsc_pkg and spsc_ram.
module spsc_back
   import spsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        empty,
   input  item_type    head,
   output logic        pop,
   output logic        done,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [16:0] rsp_segment_primes,
   output logic [27:0] rsp_prime_total,
   output logic [31:0] rsp_segment_low,
   output logic [27:0] rsp_query_count
);
   typedef enum logic [3:0] {
      S_IDLE, S_CLEAR, S_PFETCH, S_PWAIT, S_PSQ, S_PCHK, S_PDIV, S_PSTART,
      S_PMARK, S_CNT, S_FINISH, S_RESP
   } state_type;

   state_type         st_ff, st_in;
   item_type          item_ff, item_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [CNT_W-1:0]  pidx_ff, pidx_in;
   logic [15:0]       p_ff, p_in;
   logic [31:0]       sq_ff, sq_in;
   logic [15:0]       rem_ff, rem_in;
   logic [4:0]        bit_ff, bit_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic [ADDR_W-1:0] hoff_ff, hoff_in;
   logic [16:0]       cnt_ff, cnt_in;
   logic              rvld_ff, rvld_in;
   logic [ADDR_W-1:0] tag_ff, tag_in;
   logic [27:0]       rt_ff, rt_in;
   logic [27:0]       cbs_ff, cbs_in;
   logic              valid_ff, valid_in;
   logic [31:0]       low_ff, low_in;
   logic [27:0]       qcnt_ff, qcnt_in;
   logic              strobe_ff;
   logic [2:0]        status_ff;
   logic [16:0]       segp_ff;
   logic [27:0]       total_ff;
   logic [31:0]       slow_ff;
   logic [27:0]       qout_ff;

   logic               pr_we;
   logic [BASE_AW-1:0] pr_waddr;
   logic [15:0]        pr_wdata;
   logic [15:0]        pr_rdata;
   logic               bm_we;
   logic [SEG_AW-1:0]  bm_waddr;
   logic               bm_wdata;
   logic [SEG_AW-1:0]  bm_raddr;
   logic               bm_rdata;

   logic [16:0] shifted;
   logic [16:0] first;
   logic [32:0] first_abs;
   logic [27:0] seg_diff;
   logic [32:0] tag_abs;

   spsc_ram #(.WIDTH(16), .DEPTH(MAX_BASE_PRIMES)) u_prime_ram (
      .clock(clock), .we(pr_we), .waddr(pr_waddr), .wdata(pr_wdata),
      .raddr(pidx_ff[BASE_AW-1:0]), .rdata(pr_rdata)
   );

   spsc_ram #(.WIDTH(1), .DEPTH(SEG_BITS)) u_bitmap_ram (
      .clock(clock), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
      .raddr(bm_raddr), .rdata(bm_rdata)
   );

   assign shifted   = {rem_ff, low_ff[bit_ff]};
   assign first     = (rem_ff == '0) ? 17'd0 : ({1'b0, p_ff} - {1'b0, rem_ff});
   assign first_abs = {1'b0, low_ff} + 33'(first);
   assign seg_diff  = rt_ff - cbs_ff;
   assign tag_abs   = {1'b0, low_ff} + 33'(tag_ff);

   always_comb begin
      st_in    = st_ff;
      item_in  = item_ff;
      addr_in  = addr_ff;
      pidx_in  = pidx_ff;
      p_in     = p_ff;
      sq_in    = sq_ff;
      rem_in   = rem_ff;
      bit_in   = bit_ff;
      off_in   = off_ff;
      hoff_in  = hoff_ff;
      cnt_in   = cnt_ff;
      rvld_in  = rvld_ff;
      tag_in   = tag_ff;
      rt_in    = rt_ff;
      cbs_in   = cbs_ff;
      valid_in = valid_ff;
      low_in   = low_ff;
      qcnt_in  = qcnt_ff;
      pop      = 1'b0;
      done     = 1'b0;
      pr_we    = 1'b0;
      pr_waddr = head.count[BASE_AW-1:0];
      pr_wdata = head.value[15:0];
      bm_we    = 1'b0;
      bm_waddr = addr_ff[SEG_AW-1:0];
      bm_wdata = 1'b0;
      bm_raddr = addr_ff[SEG_AW-1:0];
      unique case (st_ff)
         S_IDLE: begin
            if (!empty) begin
               pop     = 1'b1;
               item_in = head;
               qcnt_in = '0;
               addr_in = '0;
               cnt_in  = '0;
               rvld_in = 1'b0;
               st_in   = S_RESP;
               if (head.status == ST_OK) begin
                  unique case (head.op)
                     CMD_LOAD: begin
                        pr_we = 1'b1;
                     end
                     CMD_RESTART: begin
                        rt_in    = '0;
                        cbs_in   = '0;
                        valid_in = 1'b0;
                        low_in   = '0;
                     end
                     CMD_SWEEP: begin
                        low_in  = head.low;
                        hoff_in = ADDR_W'(head.high - head.low);
                        st_in   = S_CLEAR;
                     end
                     CMD_QUERY: begin
                        hoff_in = ADDR_W'(head.value - low_ff);
                        st_in   = S_CNT;
                     end
                  endcase
               end
            end
         end
         S_CLEAR: begin
            bm_we   = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == SEG_LAST) begin
               pidx_in = '0;
               st_in   = S_PFETCH;
            end
         end
         S_PFETCH: begin
            // The table read of entry pidx is issued in this cycle.
            if (pidx_ff == item_ff.count) begin
               addr_in = '0;
               st_in   = S_CNT;
            end else begin
               st_in = S_PWAIT;
            end
         end
         S_PWAIT: begin
            p_in  = pr_rdata;
            st_in = S_PSQ;
         end
         S_PSQ: begin
            sq_in  = 32'(p_ff) * 32'(p_ff);
            rem_in = '0;
            bit_in = 5'd31;
            st_in  = S_PCHK;
         end
         S_PCHK: begin
            // Primes come in ascending order, so the first square past the end stops marking.
            if (sq_ff > item_ff.high) begin
               addr_in = '0;
               st_in   = S_CNT;
            end else begin
               st_in = S_PDIV;
            end
         end
         S_PDIV: begin
            // Restoring remainder of the segment low end by p, one bit a cycle.
            if (shifted >= {1'b0, p_ff}) begin
               rem_in = 16'(shifted - {1'b0, p_ff});
            end else begin
               rem_in = shifted[15:0];
            end
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               st_in = S_PSTART;
            end
         end
         S_PSTART: begin
            if ({1'b0, sq_ff} > first_abs) begin
               off_in = OFF_W'(sq_ff - low_ff);
            end else begin
               off_in = OFF_W'(first);
            end
            st_in = S_PMARK;
         end
         S_PMARK: begin
            if (off_ff > OFF_W'(hoff_ff)) begin
               pidx_in = pidx_ff + 1'b1;
               st_in   = S_PFETCH;
            end else begin
               bm_we    = 1'b1;
               bm_waddr = off_ff[SEG_AW-1:0];
               bm_wdata = 1'b1;
               off_in   = off_ff + OFF_W'(p_ff);
            end
         end
         S_CNT: begin
            rvld_in = 1'b0;
            if (addr_ff <= hoff_ff) begin
               tag_in  = addr_ff;
               rvld_in = 1'b1;
               addr_in = addr_ff + 1'b1;
            end
            if (rvld_ff && !bm_rdata && tag_abs >= 33'd2) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (addr_ff > hoff_ff && !rvld_ff) begin
               st_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (item_ff.op == CMD_SWEEP) begin
               cbs_in   = rt_ff;
               rt_in    = sat_add(rt_ff, 28'(cnt_ff));
               valid_in = 1'b1;
            end else begin
               qcnt_in = sat_add(cbs_ff, 28'(cnt_ff));
            end
            st_in = S_RESP;
         end
         S_RESP: begin
            done  = 1'b1;
            st_in = S_IDLE;
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      addr_ff   <= addr_in;
      pidx_ff   <= pidx_in;
      p_ff      <= p_in;
      sq_ff     <= sq_in;
      rem_ff    <= rem_in;
      bit_ff    <= bit_in;
      off_ff    <= off_in;
      hoff_ff   <= hoff_in;
      cnt_ff    <= cnt_in;
      tag_ff    <= tag_in;
      qcnt_ff   <= qcnt_in;
      status_ff <= item_ff.status;
      segp_ff   <= !valid_ff ? 17'd0 :
                   (seg_diff > 28'(SEGCNT_MAX)) ? SEGCNT_MAX : seg_diff[16:0];
      total_ff  <= rt_ff;
      slow_ff   <= valid_ff ? low_ff : 32'd0;
      qout_ff   <= qcnt_ff;
      if (reset) begin
         st_ff     <= S_IDLE;
         rvld_ff   <= 1'b0;
         rt_ff     <= '0;
         cbs_ff    <= '0;
         valid_ff  <= 1'b0;
         low_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         st_ff     <= st_in;
         rvld_ff   <= rvld_in;
         rt_ff     <= rt_in;
         cbs_ff    <= cbs_in;
         valid_ff  <= valid_in;
         low_ff    <= low_in;
         strobe_ff <= (st_ff == S_RESP);
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_segment_primes = segp_ff;
   assign rsp_prime_total    = total_ff;
   assign rsp_segment_low    = slow_ff;
   assign rsp_query_count    = qout_ff;
endmodule

FILE: src/segmented_prime_sieve_counter.sv
// Segmented prime sieve counter, top level.
// Depends on spsc_pkg, spsc_front, spsc_fifo and spsc_back.
//
// Use: a command beat (req_cmd, req_value) is taken when start is high and busy
// is low. Commands: load base prime, sweep next segment, query count, restart.
// Every command gives exactly one result beat: rsp_strobe is high for one cycle
// with rsp_status, rsp_segment_primes, rsp_prime_total, rsp_segment_low and
// rsp_query_count. The receiver cannot stall; results are taken as shown.
// The sieve limit is written through csr_we/csr_wdata; the user must do so only
// while the block is idle, which the block does not enforce. One command is in
// work at a time; busy stays high until its result is issued. A sweep first
// clears the whole bitmap, then for each base prime up to sqrt(high) finds its
// starting multiple in the segment and marks the multiples one at a time (single
// bitmap write port and a bit-serial remainder unit), then counts the unmarked
// bits of the segment. A query reads the bitmap from segment low up to value.
// Reset (synchronous) empties the base prime table count, the totals and the
// segment state, and sets the limit to 100000000. The bitmap and prime table
// need no clearing.
module segmented_prime_sieve_counter
   import spsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_value,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [16:0] rsp_segment_primes,
   output logic [27:0] rsp_prime_total,
   output logic [31:0] rsp_segment_low,
   output logic [27:0] rsp_query_count
);
   logic     push;
   item_type push_item;
   logic     pop;
   logic     empty;
   item_type head;
   logic     done;

   spsc_front u_front (
      .clock(clock), .reset(reset), .start(start), .req_cmd(req_cmd),
      .req_value(req_value), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .done(done), .busy(busy), .push(push), .push_item(push_item)
   );

   spsc_fifo u_fifo (
      .clock(clock), .reset(reset), .push(push), .push_item(push_item),
      .pop(pop), .empty(empty), .head(head)
   );

   spsc_back u_back (
      .clock(clock), .reset(reset), .empty(empty), .head(head), .pop(pop),
      .done(done), .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_segment_primes(rsp_segment_primes), .rsp_prime_total(rsp_prime_total),
      .rsp_segment_low(rsp_segment_low), .rsp_query_count(rsp_query_count)
   );
endmodule

FILE: src/spsc_checker.sv
// Port-level checker of the segmented prime sieve counter and its bind.
// Depends on spsc_pkg and segmented_prime_sieve_counter_macros.svh.
`include "segmented_prime_sieve_counter_macros.svh"

module spsc_checker
   import spsc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [2:0]  rsp_status,
   input logic [16:0] rsp_segment_primes,
   input logic [27:0] rsp_prime_total,
   input logic [27:0] rsp_query_count
);
   // A taken command keeps the block busy until its result comes out.
   `SPSC_ASSERT_NXT(a_busy_after_accept, clock, reset, start && !busy, busy)
   `SPSC_ASSERT_IMP(a_status_code, clock, reset, rsp_strobe, rsp_status <= ST_NOT_ASCND)
   // Only a successful query reports a count.
   `SPSC_ASSERT_IMP(a_qcount_on_fail, clock, reset, rsp_strobe && rsp_status != ST_OK,
                    rsp_query_count == 28'd0)
   `SPSC_ASSERT_IMP(a_segment_within_total, clock, reset, rsp_strobe,
                    28'(rsp_segment_primes) <= rsp_prime_total)
endmodule

bind segmented_prime_sieve_counter spsc_checker u_spsc_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
   .rsp_segment_primes(rsp_segment_primes), .rsp_prime_total(rsp_prime_total),
   .rsp_query_count(rsp_query_count)
);
